// ----- design/assert_macros.svh -----
// Assertion macros for the checker file svd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk_i, switched off while rst_ni is low.
`define SVD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent assertion on clk_i that is checked during reset too.
`define SVD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/svd_pkg.sv -----
// Types and constants for the space vector sector and duty block.
package svd_pkg;

  localparam int unsigned PeriodW  = 14;
  localparam int unsigned Root3W   = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned TW       = PeriodW + 2;   // T = 4 * period
  localparam int unsigned DataW    = 16;
  localparam int unsigned SecW     = 3;
  localparam int unsigned UaW      = 33;            // alpha * root3
  localparam int unsigned UbW      = 34;            // -(beta * T)
  localparam int unsigned XyzW     = 34;
  localparam int unsigned NW       = 36;            // duty numerators
  localparam int unsigned KShift   = 17;            // K = 131072

  localparam logic CfgPwmPeriod   = 1'b0;
  localparam logic CfgPeriodRoot3 = 1'b1;

  localparam logic [PeriodW-1:0] PwmPeriodRst   = 14'd1000;
  localparam logic [Root3W-1:0]  PeriodRoot3Rst = 16'd6928;

  localparam logic [SecW-1:0] Sec1 = 3'd1;
  localparam logic [SecW-1:0] Sec2 = 3'd2;
  localparam logic [SecW-1:0] Sec3 = 3'd3;
  localparam logic [SecW-1:0] Sec4 = 3'd4;
  localparam logic [SecW-1:0] Sec5 = 3'd5;
  localparam logic [SecW-1:0] Sec6 = 3'd6;

  typedef struct packed {
    logic signed [DataW-1:0] v_alpha;
    logic signed [DataW-1:0] v_beta;
  } in_t;

  typedef struct packed {
    logic [DataW-1:0] duty_a;
    logic [DataW-1:0] duty_b;
    logic [DataW-1:0] duty_c;
    logic [SecW-1:0]  sector;
  } out_t;

  typedef struct packed {
    logic signed [XyzW-1:0] x;
    logic signed [XyzW-1:0] y;
    logic signed [XyzW-1:0] z;
    logic [SecW-1:0]        sector;
  } xyz_t;

endpackage

// ----- design/svd_sector.sv -----
// X, Y, Z forming and sector selection from the two products.
module svd_sector (
  input  logic signed [svd_pkg::UaW-1:0] ua_i,
  input  logic signed [svd_pkg::UbW-1:0] ub_i,
  output svd_pkg::xyz_t                  xyz_o
);
  import svd_pkg::*;

  logic signed [XyzW:0]   ua_x, ub_x;
  logic        [XyzW:0]   sum_p, sum_m;
  logic signed [XyzW:0]   y_full, z_full;
  logic signed [XyzW-1:0] x, y, z;
  logic                   x_le0;

  assign ua_x  = (XyzW+1)'(ua_i);
  assign ub_x  = (XyzW+1)'(ub_i);
  assign sum_p = ub_x + ua_x;
  assign sum_m = ub_x - ua_x;

  // halve with truncation toward zero: bias negatives by one
  assign y_full = $signed(sum_p + {{XyzW{1'b0}}, sum_p[XyzW]}) >>> 1;
  assign z_full = $signed(sum_m + {{XyzW{1'b0}}, sum_m[XyzW]}) >>> 1;

  assign x     = ub_i[XyzW-1:0];
  assign y     = y_full[XyzW-1:0];
  assign z     = z_full[XyzW-1:0];
  assign x_le0 = x[XyzW-1] || (x == '0);

  always_comb begin
    xyz_o.x = x;
    xyz_o.y = y;
    xyz_o.z = z;
    if (y[XyzW-1]) begin
      if (z[XyzW-1]) xyz_o.sector = Sec5;
      else           xyz_o.sector = x_le0 ? Sec4 : Sec3;
    end else begin
      if (!z[XyzW-1]) xyz_o.sector = Sec2;
      else            xyz_o.sector = x_le0 ? Sec6 : Sec1;
    end
  end

endmodule

// ----- design/svd_duty.sv -----
// Centre-aligned compare values from X, Y, Z and the sector.
module svd_duty (
  input  svd_pkg::xyz_t         xyz_i,
  input  logic [svd_pkg::TW-1:0] t_i,
  output svd_pkg::out_t         out_o
);
  import svd_pkg::*;

  // signed divide by 2^sh, truncating toward zero; low result bits only
  function automatic logic [DataW-1:0] div_pow2(input logic signed [NW-1:0] v,
                                                 input int unsigned sh);
    logic [NW-1:0]        bias;
    logic signed [NW-1:0] q;
    bias = v[NW-1] ? ((NW'(1) << sh) - NW'(1)) : '0;
    q    = $signed(v + bias) >>> sh;
    return q[DataW-1:0];
  endfunction

  logic signed [NW-1:0] t_s, x_s, y_s, z_s, n;
  logic [DataW-1:0]     xq, yq, zq, nq, a, t8;

  assign t_s = $signed({{(NW-TW){1'b0}}, t_i});
  assign x_s = NW'(xyz_i.x);
  assign y_s = NW'(xyz_i.y);
  assign z_s = NW'(xyz_i.z);

  always_comb begin
    case (xyz_i.sector)
      Sec1, Sec4: n = t_s + x_s - z_s;
      Sec2, Sec5: n = t_s + y_s - z_s;
      default:    n = t_s - x_s + y_s;
    endcase
  end

  assign xq = div_pow2(x_s, KShift);
  assign yq = div_pow2(y_s, KShift);
  assign zq = div_pow2(z_s, KShift);
  // (n / 2) / K equals n / (2K) under truncation
  assign nq = div_pow2(n, KShift + 1);
  assign t8 = DataW'(t_i[TW-1:3]);
  assign a  = t8 + nq;

  always_comb begin
    out_o.duty_a = a;
    out_o.sector = xyz_i.sector;
    case (xyz_i.sector)
      Sec1, Sec4: begin
        out_o.duty_b = a + zq;
        out_o.duty_c = a + zq - xq;
      end
      Sec2, Sec5: begin
        out_o.duty_b = a + zq;
        out_o.duty_c = a - yq;
      end
      default: begin
        out_o.duty_c = a - yq;
        out_o.duty_b = a - yq + xq;
      end
    endcase
  end

endmodule

// ----- design/svpwm_sector_and_duty.sv -----
// Top level: space vector PWM sector and compare value pipeline.
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries one alpha/beta voltage
//   vector per transaction; output channel out_valid_o/out_ready_i carries
//   the three compare values and the sector number, one result per input.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0: timer period, 14 bits; 1: period_root3, 16 bits). T = 4 * timer period.
//   Write configuration only while no transaction is in flight.
// Stages and throughput:
//   Four register stages: input, products, X/Y/Z with sector, result.
//   One transaction is accepted every cycle unless a stall has filled every
//   stage; the two 16x17 multipliers in the product stage set the critical
//   path.
// Reset:
//   All stages empty, timer period = 1000, period_root3 = 6928.
// Stall:
//   When out_ready_i is low the result holds; earlier stages keep filling
//   until every stage is occupied, then in_ready_o drops.
module svpwm_sector_and_duty (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [svd_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  svd_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output svd_pkg::out_t                  out_data_o
);
  import svd_pkg::*;

  logic [PeriodW-1:0] timer_period_q;
  logic [Root3W-1:0]  period_root3_q;
  logic [TW-1:0]      t;

  logic v1_q, v2_q, v3_q, vo_q;
  logic en1, en2, en3, en_o;

  in_t                   in_q;
  logic signed [UaW-1:0] ua_d, ua_q;
  logic signed [UbW-1:0] bt_prod, ub_d, ub_q;
  xyz_t                  xyz_d, xyz_q;
  out_t                  out_d, out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_period_q <= PwmPeriodRst;
      period_root3_q <= PeriodRoot3Rst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPwmPeriod:   timer_period_q <= cfg_wdata_i[PeriodW-1:0];
        CfgPeriodRoot3: period_root3_q <= cfg_wdata_i[Root3W-1:0];
        default: ;
      endcase
    end
  end

  assign t = {timer_period_q, 2'b00};

  // a stage loads when it is empty or its content moves on
  assign en_o       = !vo_q || out_ready_i;
  assign en3        = !v3_q || en_o;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1)  v1_q <= in_valid_i;
      if (en2)  v2_q <= v1_q;
      if (en3)  v3_q <= v2_q;
      if (en_o) vo_q <= v3_q;
    end
  end

  assign ua_d    = UaW'(in_q.v_alpha) * UaW'($signed({1'b0, period_root3_q}));
  assign bt_prod = UbW'(in_q.v_beta) * UbW'($signed({1'b0, t}));
  assign ub_d    = -bt_prod;

  svd_sector u_sector (
    .ua_i  (ua_q),
    .ub_i  (ub_q),
    .xyz_o (xyz_d)
  );

  svd_duty u_duty (
    .xyz_i (xyz_q),
    .t_i   (t),
    .out_o (out_d)
  );

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) in_q  <= in_data_i;
    if (en2 && v1_q) begin
      ua_q <= ua_d;
      ub_q <= ub_d;
    end
    if (en3 && v2_q)  xyz_q <= xyz_d;
    if (en_o && v3_q) out_q <= out_d;
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

endmodule

// ----- design/svd_checker.sv -----
// Port-level checker for the sector and duty block, bound to the top level.
`include "assert_macros.svh"

module svd_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input svd_pkg::out_t out_data_i
);
  import svd_pkg::*;

  logic sector_ok;

  assign sector_ok = (out_data_i.sector >= Sec1) && (out_data_i.sector <= Sec6);

  `SVD_ASSERT_ALWAYS(a_empty_in_reset, !rst_ni |-> !out_valid_i, "result valid during reset")
  `SVD_ASSERT(a_valid_holds, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped")
  `SVD_ASSERT(a_data_holds, out_valid_i && !out_ready_i |=> $stable(out_data_i), "result changed")
  `SVD_ASSERT(a_sector_range, out_valid_i |-> sector_ok, "bad sector")
  `SVD_ASSERT(a_no_backpressure, out_ready_i |-> in_ready_i, "input stalled with output free")

endmodule

bind svpwm_sector_and_duty svd_checker u_svd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for svpwm_sector_and_duty: directed table, then random vectors over several periods.
module tb_top;
  import svd_pkg::*;

  localparam longint DutyDiv     = 131072;
  localparam int     NumPhases   = 8;
  localparam int     PhaseItems  = 115;
  localparam int     DrainCycles = 8;

  typedef struct packed {
    logic                cfg;
    logic                idx;
    logic [CfgDataW-1:0] wdata;
    in_t                 vec;
    logic                typed;
    out_t                want;
  } dir_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b1;
  logic                cfg_we_i    = 1'b0;
  logic                cfg_idx_i   = 1'b0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_t                out_data_o;

  // Shadow copy of the period registers for prediction.
  logic [PeriodW-1:0]  shadow_period = PwmPeriodRst;
  logic [Root3W-1:0]   shadow_root3  = PeriodRoot3Rst;

  out_t     duty_q[$];
  dir_row_t dir_steps[$];
  bit       no_idle = 1'b0;
  int       errors  = 0;

  always #5 clk_i = ~clk_i;

  svpwm_sector_and_duty dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  function automatic out_t predict_duty(in_t v);
    longint t, ua, ub, x, y, z, a, b, c;
    logic [SecW-1:0] sec;
    out_t res;
    t  = longint'(shadow_period) * 4;
    ua = longint'($signed(v.v_alpha)) * longint'(shadow_root3);
    ub = -(longint'($signed(v.v_beta)) * t);
    x  = ub;
    y  = (ub + ua) / 2;
    z  = (ub - ua) / 2;
    if (y < 0) begin
      if (z < 0) sec = Sec5;
      else sec = (x <= 0) ? Sec4 : Sec3;
    end else begin
      if (z >= 0) sec = Sec2;
      else sec = (x <= 0) ? Sec6 : Sec1;
    end
    if (sec == Sec1 || sec == Sec4) begin
      a = t / 8 + (((t + x) - z) / 2) / DutyDiv;
      b = a + z / DutyDiv;
      c = b - x / DutyDiv;
    end else if (sec == Sec2 || sec == Sec5) begin
      a = t / 8 + (((t + y) - z) / 2) / DutyDiv;
      b = a + z / DutyDiv;
      c = a - y / DutyDiv;
    end else begin
      a = t / 8 + (((t - x) + y) / 2) / DutyDiv;
      c = a - y / DutyDiv;
      b = c + x / DutyDiv;
    end
    res.duty_a = a[15:0];
    res.duty_b = b[15:0];
    res.duty_c = c[15:0];
    res.sector = sec;
    return res;
  endfunction

  function automatic dir_row_t vec_row(int alpha, int beta);
    dir_row_t r;
    r = '0;
    r.vec.v_alpha = alpha[15:0];
    r.vec.v_beta  = beta[15:0];
    return r;
  endfunction

  function automatic dir_row_t typed_row(int alpha, int beta, out_t want);
    dir_row_t r;
    r       = vec_row(alpha, beta);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic idx, logic [CfgDataW-1:0] wdata);
    dir_row_t r;
    r       = '0;
    r.cfg   = 1'b1;
    r.idx   = idx;
    r.wdata = wdata;
    return r;
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(0, 99) < 31);
  endfunction

  // Upper bits of the period word are don't-care; randomize them.
  function automatic logic [CfgDataW-1:0] period_word(int unsigned p);
    logic [CfgDataW-1:0] w;
    w = 16'($urandom_range(0, 3)) << PeriodW;
    w[PeriodW-1:0] = p[PeriodW-1:0];
    return w;
  endfunction

  function automatic int unsigned root3_of(int unsigned p);
    return int'((longint'(p) * 4 * 1732051) / 1000000);
  endfunction

  function automatic in_t rand_vector();
    in_t v;
    int  mode;
    logic [DataW-1:0] corner[5];
    corner = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
    mode = $urandom_range(0, 9);
    v.v_alpha = 16'($urandom);
    v.v_beta  = 16'($urandom);
    case (mode)
      6, 7: begin
        v.v_alpha = 16'($urandom_range(0, 600) - 300);
        v.v_beta  = 16'($urandom_range(0, 600) - 300);
      end
      8: begin
        v.v_alpha = corner[$urandom_range(0, 4)];
        v.v_beta  = corner[$urandom_range(0, 4)];
      end
      9: begin
        if ($urandom_range(0, 1)) v.v_alpha = '0;
        else v.v_beta = '0;
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_vector(in_t v, out_t want);
    while (idle_now()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= v;
    do @(posedge clk_i); while (!in_ready_o);
    duty_q.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (duty_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [CfgDataW-1:0] wdata);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= wdata;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgPwmPeriod) shadow_period = wdata[PeriodW-1:0];
    else shadow_root3 = wdata[Root3W-1:0];
    @(negedge clk_i);
  endtask

  task automatic check_field(string name, logic [DataW-1:0] want, logic [DataW-1:0] got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(0, 99) >= 31);
  end

  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (duty_q.size() == 0) begin
        $error("result transaction with nothing pending: sector %0d", out_data_o.sector);
        errors++;
      end else begin
        want = duty_q.pop_front();
        check_field("duty_a", want.duty_a, out_data_o.duty_a);
        check_field("duty_b", want.duty_b, out_data_o.duty_b);
        check_field("duty_c", want.duty_c, out_data_o.duty_c);
        check_field("sector", DataW'(want.sector), DataW'(out_data_o.sector));
      end
    end
  end

  initial begin : stimulus
    dir_row_t    row;
    int unsigned p;
    int unsigned r3;

    rst_ni <= 1'b0;

    // Zero vector at reset period: all compares sit at T/8.
    dir_steps.push_back(typed_row(0, 0, out_t'{16'd500, 16'd500, 16'd500, Sec2}));
    dir_steps.push_back(vec_row(32767, 0));
    dir_steps.push_back(vec_row(-32768, 0));
    dir_steps.push_back(vec_row(0, 32767));
    dir_steps.push_back(vec_row(0, -32768));
    dir_steps.push_back(vec_row(32767, 32767));
    dir_steps.push_back(vec_row(-32768, -32768));
    dir_steps.push_back(vec_row(32767, -32768));
    dir_steps.push_back(vec_row(-32768, 32767));
    dir_steps.push_back(vec_row(1, -1));
    // one vector in the middle of each sector
    dir_steps.push_back(vec_row(13856, 8000));
    dir_steps.push_back(vec_row(0, 16000));
    dir_steps.push_back(vec_row(-13856, 8000));
    dir_steps.push_back(vec_row(-13856, -8000));
    dir_steps.push_back(vec_row(0, -16000));
    dir_steps.push_back(vec_row(13856, -8000));
    // zero period; upper data bits set must be dropped
    dir_steps.push_back(cfg_row(CfgPwmPeriod, 16'hC000));
    dir_steps.push_back(typed_row(0, 0, out_t'{16'd0, 16'd0, 16'd0, Sec2}));
    dir_steps.push_back(vec_row(32767, -32768));
    // widest period with root3 register not matching it
    dir_steps.push_back(cfg_row(CfgPwmPeriod, 16'hFFFF));
    dir_steps.push_back(cfg_row(CfgPeriodRoot3, 16'hFFFF));
    dir_steps.push_back(vec_row(-32768, 32767));
    dir_steps.push_back(vec_row(32767, 32767));
    dir_steps.push_back(cfg_row(CfgPeriodRoot3, 16'h0000));
    dir_steps.push_back(vec_row(-32768, -1));

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_steps[i]) begin
      row = dir_steps[i];
      if (row.cfg) begin
        wait_drained();
        write_cfg(row.idx, row.wdata);
      end else begin
        send_vector(row.vec, row.typed ? row.want : predict_duty(row.vec));
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          p  = 32'(PwmPeriodRst);
          r3 = 32'(PeriodRoot3Rst);
        end
        1: begin
          p  = 1;
          r3 = root3_of(1);
        end
        2: begin
          p  = 9459;
          r3 = root3_of(9459);
        end
        4: begin
          p  = $urandom_range(1, 9459);
          r3 = $urandom_range(0, 65535);
        end
        5: begin
          p  = 0;
          r3 = $urandom_range(0, 65535);
        end
        6: begin
          p  = 16383;
          r3 = 65535;
        end
        default: begin
          p  = $urandom_range(1, 9459);
          r3 = root3_of(p);
        end
      endcase
      write_cfg(CfgPwmPeriod, period_word(p));
      write_cfg(CfgPeriodRoot3, r3[Root3W-1:0]);
      // back-to-back traffic in phase 3 only, random idles in the other phases
      no_idle = (ph == 3);
      repeat (PhaseItems) begin
        row.vec = rand_vector();
        send_vector(row.vec, predict_duty(row.vec));
      end
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/svd_pkg.sv
design/svd_sector.sv
design/svd_duty.sv
design/svpwm_sector_and_duty.sv
design/svd_checker.sv
tb/tb_top.sv
